/* src/dtq_pkg.sv */
// Shared types and constants for the delta timeout queue.
// Depends on nothing; dtq_ctrl, dtq_datapath and delta_timeout_queue import it.
`default_nettype none

package dtq_pkg;

    // Operation codes of the request item
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Widths of the item fields
    localparam int OP_W      = 2;
    localparam int TASK_W    = 4;
    localparam int TIMEOUT_W = 32;
    localparam int PEND_W    = 5;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RM_READ,
        ST_RM_CHECK,
        ST_RM_SUCC_READ,
        ST_RM_SUCC_WRITE,
        ST_RM_LINK,
        ST_INS_START,
        ST_INS_CHECK,
        ST_INS_SPLIT,
        ST_INS_NEW,
        ST_INS_LINK,
        ST_TK_READ,
        ST_TK_DEC,
        ST_TK_SCAN,
        ST_EMIT_INIT,
        ST_EMIT,
        ST_DONE
    } state_t;

    // Node memory read address source
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_SUCC,
        RD_OLD
    } rd_sel_t;

    // Node memory write address and data source
    typedef enum logic [2:0] {
        WR_SUCC_ADD,
        WR_PREV_RM,
        WR_CUR_SPLIT,
        WR_NEW,
        WR_PREV_INS,
        WR_HEAD_DEC
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    walk_init;
        logic    re;
        rd_sel_t rd_sel;
        logic    we;
        wr_sel_t wr_sel;
        logic    advance;
        logic    t_sub;
        logic    rm_save;
        logic    rm_unlink;
        logic    ins_link;
        logic    tk_start;
        logic    pop;
        logic    emit_init;
        logic    emit_load;
        logic    done_load;
    } dtq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_is_arm;
        logic op_is_cancel;
        logic op_is_tick;
        logic task_ok;
        logic task_queued;
        logic arm_insert;
        logic count_zero;
        logic count_gt1;
        logic idx_last;
        logic match;
        logic t_ge;
        logic delta_zero;
        logic delta_one;
        logic at_head;
        logic out_free;
        logic emit_last;
    } dtq_status_t;

endpackage

`default_nettype wire

/* src/dtq_req_if.sv */
// Request channel: valid/ready handshake carrying one queue operation item.
// Depends on nothing.
`default_nettype none

interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  task_id;
    logic [31:0] timeout;
    logic        no_timeout;

    modport source (
        output valid, operation, task_id, timeout, no_timeout,
        input  ready
    );
    modport sink (
        input  valid, operation, task_id, timeout, no_timeout,
        output ready
    );
endinterface

`default_nettype wire

/* src/dtq_rsp_if.sv */
// Result channel: valid/ready handshake carrying one result item.
// Depends on nothing.
`default_nettype none

interface dtq_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] expired_task;
    logic       expired;
    logic       last;
    logic [4:0] pending_count;

    modport source (
        output valid, expired_task, expired, last, pending_count,
        input  ready
    );
    modport sink (
        input  valid, expired_task, expired, last, pending_count,
        output ready
    );
endinterface

`default_nettype wire

/* src/dtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/dtq_ctrl.sv */
// Controller of the delta timeout queue: sequences list walks, node updates
// and result emission. Depends on dtq_pkg.
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire dtq_status_t status,
    output dtq_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.task_ok && (status.op_is_arm || status.op_is_cancel))
                begin
                    if (status.task_queued)
                    begin
                        state_next = ST_RM_READ;
                    end
                    else if (status.arm_insert)
                    begin
                        state_next = ST_INS_START;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (status.op_is_tick && !status.count_zero)
                begin
                    state_next = ST_TK_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RM_READ:
            begin
                state_next = ST_RM_CHECK;
            end
            ST_RM_CHECK:
            begin
                if (status.match)
                begin
                    state_next = status.idx_last ? ST_RM_LINK : ST_RM_SUCC_READ;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RM_SUCC_READ:
            begin
                state_next = ST_RM_SUCC_WRITE;
            end
            ST_RM_SUCC_WRITE:
            begin
                state_next = ST_RM_LINK;
            end
            ST_RM_LINK:
            begin
                state_next = status.arm_insert ? ST_INS_START : ST_DONE;
            end
            ST_INS_START:
            begin
                state_next = status.count_zero ? ST_INS_NEW : ST_INS_CHECK;
            end
            ST_INS_CHECK:
            begin
                if (!status.t_ge)
                begin
                    state_next = ST_INS_SPLIT;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_INS_NEW;
                end
            end
            ST_INS_SPLIT:
            begin
                state_next = ST_INS_NEW;
            end
            ST_INS_NEW:
            begin
                state_next = ST_INS_LINK;
            end
            ST_INS_LINK:
            begin
                state_next = ST_DONE;
            end
            ST_TK_READ:
            begin
                state_next = ST_TK_DEC;
            end
            ST_TK_DEC:
            begin
                if (status.delta_zero || status.delta_one)
                begin
                    state_next = status.count_gt1 ? ST_TK_SCAN : ST_EMIT_INIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TK_SCAN:
            begin
                if (!status.delta_zero || !status.count_gt1)
                begin
                    state_next = ST_EMIT_INIT;
                end
            end
            ST_EMIT_INIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.walk_init = 1'b1;
            end
            ST_RM_READ:
            begin
                cmd.re     = 1'b1;
                cmd.rd_sel = RD_HEAD;
            end
            ST_RM_CHECK:
            begin
                if (status.match)
                begin
                    cmd.rm_save = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.re      = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                end
            end
            ST_RM_SUCC_READ:
            begin
                cmd.re     = 1'b1;
                cmd.rd_sel = RD_SUCC;
            end
            ST_RM_SUCC_WRITE:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_SUCC_ADD;
            end
            ST_RM_LINK:
            begin
                cmd.rm_unlink = 1'b1;
                cmd.we        = !status.at_head;
                cmd.wr_sel    = WR_PREV_RM;
            end
            ST_INS_START:
            begin
                cmd.walk_init = 1'b1;
                cmd.re        = !status.count_zero;
                cmd.rd_sel    = RD_HEAD;
            end
            ST_INS_CHECK:
            begin
                if (status.t_ge)
                begin
                    cmd.t_sub   = 1'b1;
                    cmd.advance = 1'b1;
                    cmd.re      = !status.idx_last;
                    cmd.rd_sel  = RD_NEXT;
                end
            end
            ST_INS_SPLIT:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_CUR_SPLIT;
            end
            ST_INS_NEW:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_NEW;
            end
            ST_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                cmd.we       = !status.at_head;
                cmd.wr_sel   = WR_PREV_INS;
            end
            ST_TK_READ:
            begin
                cmd.tk_start = 1'b1;
                cmd.re       = 1'b1;
                cmd.rd_sel   = RD_HEAD;
            end
            ST_TK_DEC:
            begin
                if (status.delta_zero || status.delta_one)
                begin
                    cmd.pop    = 1'b1;
                    cmd.re     = status.count_gt1;
                    cmd.rd_sel = RD_NEXT;
                end
                else
                begin
                    cmd.we     = 1'b1;
                    cmd.wr_sel = WR_HEAD_DEC;
                end
            end
            ST_TK_SCAN:
            begin
                if (status.delta_zero)
                begin
                    cmd.pop    = 1'b1;
                    cmd.re     = status.count_gt1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                cmd.re        = 1'b1;
                cmd.rd_sel    = RD_OLD;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.re        = !status.emit_last;
                    cmd.rd_sel    = RD_NEXT;
                end
            end
            ST_DONE:
            begin
                cmd.done_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/dtq_datapath.sv */
// Datapath of the delta timeout queue: linked node memory indexed by task,
// head pointer, queue count, queued flags, walk registers and result register.
// Depends on dtq_pkg and dtq_ram.
`default_nettype none

module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int TICK_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request payload
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [TASK_W-1:0]    task_id,
    input  wire logic [TIMEOUT_W-1:0] timeout,
    input  wire logic                 no_timeout,
    // control
    input  wire dtq_cmd_t             cmd,
    output dtq_status_t               status,
    // result channel
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [TASK_W-1:0]         expired_task,
    output logic                      expired,
    output logic                      last,
    output logic [PEND_W-1:0]         pending_count
);

    localparam int ID_W   = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int NODE_W = ID_W + TICK_WIDTH;
    localparam logic [63:0] TICK_MAX = (64'd1 << TICK_WIDTH) - 64'd1;

    // Request registers
    logic [OP_W-1:0]       op_reg;
    logic [ID_W-1:0]       task_reg;
    logic                  task_ok_reg;
    logic                  nt_reg;
    logic [TICK_WIDTH-1:0] t_reg;

    // List state
    logic [ID_W-1:0]       head_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [MAX_TASKS-1:0]  flag_reg;

    // Walk registers
    logic [ID_W-1:0]       cur_reg;
    logic [ID_W-1:0]       prev_reg;
    logic [TICK_WIDTH-1:0] prev_delta_reg;
    logic                  at_head_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [ID_W-1:0]       rm_next_reg;
    logic [TICK_WIDTH-1:0] rm_delta_reg;
    logic [ID_W-1:0]       old_head_reg;
    logic [CNT_W-1:0]      exp_n_reg;
    logic [CNT_W-1:0]      k_reg;

    // Result register
    logic                  out_valid_reg;
    logic [TASK_W-1:0]     out_task_reg;
    logic                  out_expired_reg;
    logic                  out_last_reg;
    logic [PEND_W-1:0]     out_pend_reg;

    // Node memory signals
    logic                  ram_we;
    logic [ID_W-1:0]       ram_waddr;
    logic [NODE_W-1:0]     ram_wdata;
    logic [ID_W-1:0]       ram_raddr;
    logic [NODE_W-1:0]     ram_rdata;
    logic [ID_W-1:0]       node_next;
    logic [TICK_WIDTH-1:0] node_delta;

    // Field conversions
    logic [63:0]           timeout_ext;
    logic [63:0]           t_sat;
    logic [ID_W+TASK_W-1:0] tid_ext;
    logic [ID_W+TASK_W-1:0] cur_ext;
    logic [CNT_W+PEND_W-1:0] cnt_ext;
    logic                  out_free;

    dtq_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_TASKS)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign node_next  = ram_rdata[NODE_W-1:TICK_WIDTH];
    assign node_delta = ram_rdata[TICK_WIDTH-1:0];

    // Timeout saturation and id/count width conversion
    assign timeout_ext = 64'(timeout);
    assign t_sat       = (timeout_ext > TICK_MAX) ? TICK_MAX : timeout_ext;
    assign tid_ext     = (ID_W + TASK_W)'(task_id);
    assign cur_ext     = (ID_W + TASK_W)'(cur_reg);
    assign cnt_ext     = (CNT_W + PEND_W)'(count_reg);
    assign out_free    = !out_valid_reg || rsp_ready;

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: ram_raddr = head_reg;
            RD_NEXT: ram_raddr = node_next;
            RD_SUCC: ram_raddr = rm_next_reg;
            RD_OLD:  ram_raddr = old_head_reg;
            default: ram_raddr = head_reg;
        endcase
    end

    // Write address and data
    always_comb
    begin
        ram_we = cmd.we;
        case (cmd.wr_sel)
            WR_SUCC_ADD:
            begin
                ram_waddr = rm_next_reg;
                ram_wdata = {node_next, node_delta + rm_delta_reg};
            end
            WR_PREV_RM:
            begin
                ram_waddr = prev_reg;
                ram_wdata = {rm_next_reg, prev_delta_reg};
            end
            WR_CUR_SPLIT:
            begin
                ram_waddr = cur_reg;
                ram_wdata = {node_next, node_delta - t_reg};
            end
            WR_NEW:
            begin
                ram_waddr = task_reg;
                ram_wdata = {cur_reg, t_reg};
            end
            WR_PREV_INS:
            begin
                ram_waddr = prev_reg;
                ram_wdata = {task_reg, prev_delta_reg};
            end
            WR_HEAD_DEC:
            begin
                ram_waddr = cur_reg;
                ram_wdata = {node_next, node_delta - TICK_WIDTH'(1)};
            end
            default:
            begin
                ram_waddr = cur_reg;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    // Status to the controller
    always_comb
    begin
        status.op_is_arm    = (op_reg == OP_ARM);
        status.op_is_cancel = (op_reg == OP_CANCEL);
        status.op_is_tick   = (op_reg == OP_TICK);
        status.task_ok      = task_ok_reg;
        status.task_queued  = flag_reg[task_reg];
        status.arm_insert   = (op_reg == OP_ARM) && !nt_reg;
        status.count_zero   = (count_reg == '0);
        status.count_gt1    = (count_reg > CNT_W'(1));
        status.idx_last     = ((idx_reg + CNT_W'(1)) >= count_reg);
        status.match        = (cur_reg == task_reg);
        status.t_ge         = (t_reg >= node_delta);
        status.delta_zero   = (node_delta == '0);
        status.delta_one    = (node_delta == TICK_WIDTH'(1));
        status.at_head      = at_head_reg;
        status.out_free     = out_free;
        status.emit_last    = ((k_reg + CNT_W'(1)) == exp_n_reg);
    end

    // List state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rm_unlink)
            begin
                count_reg          <= count_reg - CNT_W'(1);
                flag_reg[task_reg] <= 1'b0;
            end
            else if (cmd.ins_link)
            begin
                count_reg          <= count_reg + CNT_W'(1);
                flag_reg[task_reg] <= 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg         <= count_reg - CNT_W'(1);
                flag_reg[cur_reg] <= 1'b0;
            end

            if (cmd.emit_load || cmd.done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        // request capture
        if (cmd.capture)
        begin
            op_reg      <= operation;
            task_reg    <= tid_ext[ID_W-1:0];
            task_ok_reg <= (32'(task_id) < MAX_TASKS);
            nt_reg      <= no_timeout;
            t_reg       <= t_sat[TICK_WIDTH-1:0];
        end
        else if (cmd.t_sub)
        begin
            t_reg <= t_reg - node_delta;
        end

        // head pointer
        if (cmd.rm_unlink && at_head_reg)
        begin
            head_reg <= rm_next_reg;
        end
        else if (cmd.ins_link && at_head_reg)
        begin
            head_reg <= task_reg;
        end
        else if (cmd.pop)
        begin
            head_reg <= node_next;
        end

        // walk position
        if (cmd.walk_init)
        begin
            cur_reg     <= head_reg;
            at_head_reg <= 1'b1;
            idx_reg     <= '0;
        end
        else if (cmd.advance)
        begin
            cur_reg        <= node_next;
            prev_reg       <= cur_reg;
            prev_delta_reg <= node_delta;
            at_head_reg    <= 1'b0;
            idx_reg        <= idx_reg + CNT_W'(1);
        end
        else if (cmd.pop || cmd.emit_load)
        begin
            cur_reg <= node_next;
        end
        else if (cmd.emit_init)
        begin
            cur_reg <= old_head_reg;
        end

        // node being removed
        if (cmd.rm_save)
        begin
            rm_next_reg  <= node_next;
            rm_delta_reg <= node_delta;
        end

        // expiry bookkeeping
        if (cmd.tk_start)
        begin
            old_head_reg <= head_reg;
            exp_n_reg    <= '0;
        end
        else if (cmd.pop)
        begin
            exp_n_reg <= exp_n_reg + CNT_W'(1);
        end

        if (cmd.emit_init)
        begin
            k_reg <= '0;
        end
        else if (cmd.emit_load)
        begin
            k_reg <= k_reg + CNT_W'(1);
        end

        // result payload
        if (cmd.emit_load)
        begin
            out_task_reg    <= cur_ext[TASK_W-1:0];
            out_expired_reg <= 1'b1;
            out_last_reg    <= ((k_reg + CNT_W'(1)) == exp_n_reg);
            out_pend_reg    <= cnt_ext[PEND_W-1:0];
        end
        else if (cmd.done_load)
        begin
            out_task_reg    <= '0;
            out_expired_reg <= 1'b0;
            out_last_reg    <= 1'b1;
            out_pend_reg    <= cnt_ext[PEND_W-1:0];
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign expired_task  = out_task_reg;
    assign expired       = out_expired_reg;
    assign last          = out_last_reg;
    assign pending_count = out_pend_reg;

endmodule

`default_nettype wire

/* src/delta_timeout_queue.sv */
// Top level of the delta timeout queue: controller, datapath and channels.
// Depends on dtq_pkg, dtq_req_if, dtq_rsp_if, dtq_ctrl and dtq_datapath.
//
// Task timeouts are kept as a linked list in a node memory indexed by task,
// each node holding its ticks relative to its predecessor. One item is worked
// on at a time and the list is walked one node per cycle through the node
// memory's single read port. Unlinking a task walks the nodes ahead of it and,
// when it has a successor, adds its delta to that successor. Linking walks to
// the insertion point and, when it lands ahead of a node, takes the new delta
// off that node. A tick that expires tasks unlinks each expired task and then
// reports them one by one; a result stall holds the reporting. Results sit in
// an output register, so the next request is taken while the last result of
// the previous one waits. No clearing pass is needed after reset.
`default_nettype none

module delta_timeout_queue
    import dtq_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int TICK_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dtq_req_if.sink    req,
    dtq_rsp_if.source  rsp
);

    dtq_cmd_t    cmd;
    dtq_status_t status;
    logic        in_ready;

    assign req.ready = in_ready;

    // Sequencer
    dtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // List storage and result register
    dtq_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (req.operation),
        .task_id       (req.task_id),
        .timeout       (req.timeout),
        .no_timeout    (req.no_timeout),
        .cmd           (cmd),
        .status        (status),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .expired_task  (rsp.expired_task),
        .expired       (rsp.expired),
        .last          (rsp.last),
        .pending_count (rsp.pending_count)
    );

endmodule

`default_nettype wire
